@@ rtl/serial_node_link_controller_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the serial node link controller
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SERIAL_NODE_LINK_CONTROLLER_TOP_ASSERT_SVH
`define SERIAL_NODE_LINK_CONTROLLER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SNLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SNLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/snlc_pkg.sv @@
// ----------------------------------------------------------------------------
// snlc_pkg
// Shared codes, register indexes and word layouts of the serial node link
// controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package snlc_pkg;

  // Default width of the millisecond countdown
  localparam int unsigned DELAY_WIDTH_DEF = 16;

  // Stream word widths
  localparam int unsigned IN_W   = 32;
  localparam int unsigned USER_W = 3;
  localparam int unsigned OUT_W  = 24;

  // Input word layout
  localparam int unsigned IN_ELAPSED_LSB = 0;
  localparam int unsigned IN_PORT_OK     = 16;
  localparam int unsigned IN_INFO        = 17;
  localparam int unsigned IN_CHECK_OK    = 18;
  localparam int unsigned IN_IDENTIFY    = 19;
  localparam int unsigned IN_CODE_LSB    = 20;

  // Result word layout
  localparam int unsigned OUT_STATE_LSB   = 0;
  localparam int unsigned OUT_SEND_LSB    = 3;
  localparam int unsigned OUT_TX          = 5;
  localparam int unsigned OUT_FWD         = 6;
  localparam int unsigned OUT_PORT_RESET  = 7;
  localparam int unsigned OUT_ATTACHED    = 8;
  localparam int unsigned OUT_TYPE_LSB    = 9;
  localparam int unsigned OUT_OUTCOME_LSB = 14;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_RESET_DELAY   = 3'd0,
    REG_OPEN_RETRY    = 3'd1,
    REG_IDENT_TIMEOUT = 3'd2,
    REG_STATUS_TIMEOUT = 3'd3,
    REG_IDLE_POLL     = 3'd4,
    REG_MSG_RETRY     = 3'd5,
    REG_IDENT_LIMIT   = 3'd6,
    REG_MSG_LIMIT     = 3'd7
  } reg_index_t;

  // Register reset values
  localparam logic [15:0] RST_RESET_DELAY    = 16'd1000;
  localparam logic [15:0] RST_OPEN_RETRY     = 16'd5000;
  localparam logic [15:0] RST_IDENT_TIMEOUT  = 16'd1000;
  localparam logic [15:0] RST_STATUS_TIMEOUT = 16'd2000;
  localparam logic [15:0] RST_IDLE_POLL      = 16'd10000;
  localparam logic [15:0] RST_MSG_RETRY      = 16'd500;
  localparam logic [4:0]  RST_IDENT_LIMIT    = 5'd10;
  localparam logic [4:0]  RST_MSG_LIMIT      = 5'd20;

  // Retries loaded when a status poll starts
  localparam logic [4:0] STATUS_RETRIES = 5'd4;

  // Highest valid node type code
  localparam logic [4:0] MAX_NODE_TYPE = 5'd18;

  // Event kinds
  typedef enum logic [2:0] {
    K_TICK    = 3'd0,
    K_UPDATED = 3'd1,
    K_WRITE   = 3'd2,
    K_MESSAGE = 3'd3,
    K_ACK     = 3'd4,
    K_NAK     = 3'd5,
    K_ERROR   = 3'd6,
    K_HANGUP  = 3'd7
  } kind_t;

  // Link state codes as shown in the result word
  localparam logic [2:0] LS_OPEN   = 3'd0;
  localparam logic [2:0] LS_IDENT  = 3'd1;
  localparam logic [2:0] LS_IDLE   = 3'd2;
  localparam logic [2:0] LS_AWAIT  = 3'd3;
  localparam logic [2:0] LS_STATUS = 3'd4;

  // Message to send
  typedef enum logic [1:0] {
    SEND_NONE   = 2'd0,
    SEND_NODE   = 2'd1,
    SEND_STATUS = 2'd2,
    SEND_IDENT  = 2'd3
  } send_t;

  // Outcome codes
  typedef enum logic [3:0] {
    OC_NONE         = 4'd0,
    OC_OPENED       = 4'd1,
    OC_OPEN_FAILED  = 4'd2,
    OC_SEND_DROPPED = 4'd3,
    OC_EXHAUSTED    = 4'd4,
    OC_INFO         = 4'd5,
    OC_INVALID      = 4'd6,
    OC_UNKNOWN_DROP = 4'd7,
    OC_IDENTIFIED   = 4'd8,
    OC_UNKNOWN_TYPE = 4'd9,
    OC_NOT_IDENTIFY = 4'd10,
    OC_ERROR_RESET  = 4'd11,
    OC_HANGUP       = 4'd12,
    OC_CLOSED       = 4'd13
  } outcome_t;

endpackage

`default_nettype wire

@@ rtl/serial_node_link_controller_top.sv @@
// ----------------------------------------------------------------------------
// serial_node_link_controller_top
// Link state machine for one serial port to an instrument node.
// Usage: each input word on s_* is one link event (s_tuser holds the event
// kind: tick, node updated, write ready, message, ack, nak, error, hangup).
// Every event yields exactly one result word on m_*, giving the link state
// after the event, which message to send, the transmit request, whether the
// received message goes to the node handler, node identity and an outcome.
// The user must write registers through cfg_* only while no event is in
// flight; the block does not enforce this. cfg_ready is always high.
// Each event waits in the input register; its result word is registered.
// Throughput: one event per cycle while the result stream is not stalled;
// the link state register is updated in the same cycle the event leaves the
// input register, so back-to-back events see each other's effect.
// Reset: registers return to defaults, the link enters open delay with the
// reset delay loaded, and both stream stages empty.
// Stall: while m_tready is low the result holds; one more event waits in the
// input register, after which s_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module serial_node_link_controller_top #(
  parameter int unsigned DELAY_WIDTH = snlc_pkg::DELAY_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Event stream
  input  wire logic                        s_tvalid,
  output      logic                        s_tready,
  // elapsed_ms[15:0], port_ok, is_informational, check_ok, is_identify,
  // device_code[4:0], zero fill
  input  wire logic [snlc_pkg::IN_W-1:0]   s_tdata,
  // kind[2:0]
  input  wire logic [snlc_pkg::USER_W-1:0] s_tuser,
  // Result stream
  output      logic                        m_tvalid,
  input  wire logic                        m_tready,
  // link_state[2:0], send_kind[1:0], transmit_wanted, forward_to_node,
  // port_reset, node_attached, attached_type[4:0], outcome[3:0], zero fill
  output      logic [snlc_pkg::OUT_W-1:0]  m_tdata,
  // Configuration writes
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [15:0]                 cfg_data
);

  import snlc_pkg::*;

  // Width used to compare delays against the 16-bit elapsed count
  localparam int unsigned CW = (DELAY_WIDTH > 16) ? DELAY_WIDTH : 16;
  localparam logic [CW-1:0] DMAX_W = CW'((64'd1 << DELAY_WIDTH) - 64'd1);

  // One-hot link phase
  typedef enum logic [4:0] {
    PH_OPEN   = 5'b00001,
    PH_IDENT  = 5'b00010,
    PH_IDLE   = 5'b00100,
    PH_AWAIT  = 5'b01000,
    PH_STATUS = 5'b10000
  } phase_t;

  // Link state plus per-event flags, worked on as one value
  typedef struct packed {
    phase_t                 phase;
    logic [DELAY_WIDTH-1:0] dl;
    logic [4:0]             rl;
    logic                   up;
    logic                   np;
    logic [4:0]             nt;
    logic                   tx;
    outcome_t               oc;
    logic                   pr;
  } work_t;

  // Configuration registers
  logic [15:0] reset_delay;
  logic [15:0] open_retry_delay;
  logic [15:0] ident_timeout;
  logic [15:0] status_timeout;
  logic [15:0] idle_poll_delay;
  logic [15:0] msg_retry_delay;
  logic [4:0]  ident_limit;
  logic [4:0]  msg_limit;

  // Link state registers
  phase_t                 link_phase;
  logic [DELAY_WIDTH-1:0] delay_left;
  logic [4:0]             retries_left;
  logic                   update_pending;
  logic                   node_present;
  logic [4:0]             node_type;
  logic                   tx_requested;

  // Input stage
  logic        in_valid;
  kind_t       in_kind;
  logic [15:0] in_elapsed;
  logic        in_port_ok;
  logic        in_info;
  logic        in_check_ok;
  logic        in_identify;
  logic [4:0]  in_code;

  logic             advance;
  work_t            w;
  send_t            send;
  logic             fwd;
  logic [2:0]       state_code;
  logic [OUT_W-1:0] res_word;

  // Loaded delays saturate at the countdown width
  function automatic logic [DELAY_WIDTH-1:0] sat_delay(input logic [15:0] v);
    logic [CW-1:0] ve;
    ve = CW'(v);
    if (ve > DMAX_W) begin
      ve = DMAX_W;
    end
    return ve[DELAY_WIDTH-1:0];
  endfunction

  // Drop the node, close the port, restart the open delay
  function automatic work_t link_reset(input work_t wi, input logic [15:0] rd);
    work_t wo;
    wo       = wi;
    wo.np    = 1'b0;
    wo.nt    = '0;
    wo.tx    = 1'b0;
    wo.phase = PH_OPEN;
    wo.dl    = sat_delay(rd);
    wo.pr    = 1'b1;
    return wo;
  endfunction

  // Enter idle wait; a pending node update starts a send right away
  function automatic work_t go_idle(input work_t wi, input logic [4:0] lim,
                                    input logic [15:0] retry_d,
                                    input logic [15:0] poll_d);
    work_t wo;
    wo       = wi;
    wo.phase = PH_IDLE;
    if (wo.up) begin
      wo.up    = 1'b0;
      wo.phase = PH_AWAIT;
      wo.rl    = lim;
      if (wo.rl != 5'd0) begin
        wo.rl = wo.rl - 5'd1;
        wo.dl = sat_delay(retry_d);
        wo.tx = 1'b1;
      end else begin
        wo.oc    = OC_SEND_DROPPED;
        wo.phase = PH_IDLE;
        wo.dl    = sat_delay(poll_d);
      end
    end else begin
      wo.dl = sat_delay(poll_d);
    end
    return wo;
  endfunction

  // One node message attempt, or give up and go idle
  function automatic work_t try_send(input work_t wi, input logic [4:0] lim,
                                     input logic [15:0] retry_d,
                                     input logic [15:0] poll_d);
    work_t wo;
    wo = wi;
    if (wo.rl != 5'd0) begin
      wo.rl = wo.rl - 5'd1;
      wo.dl = sat_delay(retry_d);
      wo.tx = 1'b1;
    end else begin
      wo.oc = OC_SEND_DROPPED;
      wo    = go_idle(wo, lim, retry_d, poll_d);
    end
    return wo;
  endfunction

  // Configuration port: always ready, writes are registered
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_delay      <= RST_RESET_DELAY;
      open_retry_delay <= RST_OPEN_RETRY;
      ident_timeout    <= RST_IDENT_TIMEOUT;
      status_timeout   <= RST_STATUS_TIMEOUT;
      idle_poll_delay  <= RST_IDLE_POLL;
      msg_retry_delay  <= RST_MSG_RETRY;
      ident_limit      <= RST_IDENT_LIMIT;
      msg_limit        <= RST_MSG_LIMIT;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_RESET_DELAY:    reset_delay      <= cfg_data;
        REG_OPEN_RETRY:     open_retry_delay <= cfg_data;
        REG_IDENT_TIMEOUT:  ident_timeout    <= cfg_data;
        REG_STATUS_TIMEOUT: status_timeout   <= cfg_data;
        REG_IDLE_POLL:      idle_poll_delay  <= cfg_data;
        REG_MSG_RETRY:      msg_retry_delay  <= cfg_data;
        REG_IDENT_LIMIT:    ident_limit      <= cfg_data[4:0];
        REG_MSG_LIMIT:      msg_limit        <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Stream handshakes: the input stage moves on when the result slot is free
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind     <= kind_t'(s_tuser);
      in_elapsed  <= s_tdata[IN_ELAPSED_LSB +: 16];
      in_port_ok  <= s_tdata[IN_PORT_OK];
      in_info     <= s_tdata[IN_INFO];
      in_check_ok <= s_tdata[IN_CHECK_OK];
      in_identify <= s_tdata[IN_IDENTIFY];
      in_code     <= s_tdata[IN_CODE_LSB +: 5];
    end
  end

  // Event processing
  always_comb begin
    w.phase = link_phase;
    w.dl    = delay_left;
    w.rl    = retries_left;
    w.up    = update_pending;
    w.np    = node_present;
    w.nt    = node_type;
    w.tx    = tx_requested;
    w.oc    = OC_NONE;
    w.pr    = 1'b0;
    send    = SEND_NONE;
    fwd     = 1'b0;

    case (in_kind)
      K_TICK: begin
        if (w.dl != '0) begin
          if (CW'(in_elapsed) < CW'(w.dl)) begin
            w.dl = DELAY_WIDTH'(CW'(w.dl) - CW'(in_elapsed));
          end else begin
            w.dl = '0;
            // Countdown expired
            case (w.phase)
              PH_OPEN: begin
                if (in_port_ok) begin
                  w.rl    = ident_limit;
                  w.phase = PH_IDENT;
                  w.tx    = 1'b1;
                  w.oc    = OC_OPENED;
                end else begin
                  w.dl = sat_delay(open_retry_delay);
                  w.oc = OC_OPEN_FAILED;
                end
              end
              PH_IDENT, PH_STATUS: begin
                if (w.rl != 5'd0) begin
                  w.rl = w.rl - 5'd1;
                  w.tx = 1'b1;
                end else begin
                  w.oc = OC_EXHAUSTED;
                  w    = link_reset(w, reset_delay);
                end
              end
              PH_IDLE: begin
                w.rl    = STATUS_RETRIES;
                w.phase = PH_STATUS;
                w.tx    = 1'b1;
              end
              default: begin
                w = try_send(w, msg_limit, msg_retry_delay, idle_poll_delay);
              end
            endcase
          end
        end
      end
      K_UPDATED: begin
        if (w.phase == PH_IDLE) begin
          w.phase = PH_AWAIT;
          w.rl    = msg_limit;
          w       = try_send(w, msg_limit, msg_retry_delay, idle_poll_delay);
        end else begin
          w.up = 1'b1;
        end
      end
      K_WRITE: begin
        case (w.phase)
          PH_AWAIT: send = SEND_NODE;
          PH_STATUS: begin
            send = SEND_STATUS;
            w.dl = sat_delay(status_timeout);
          end
          PH_IDENT: begin
            send = SEND_IDENT;
            w.dl = sat_delay(ident_timeout);
          end
          default: send = SEND_NONE;
        endcase
        w.tx = 1'b0;
      end
      K_MESSAGE: begin
        if (w.phase == PH_OPEN) begin
          w.oc = OC_CLOSED;
        end else if (in_info) begin
          w.oc = OC_INFO;
        end else if (!in_check_ok) begin
          w.oc = OC_INVALID;
        end else if (w.phase == PH_IDENT) begin
          if (!in_identify) begin
            w.oc = OC_NOT_IDENTIFY;
          end else if (in_code <= MAX_NODE_TYPE) begin
            w.np = 1'b1;
            w.nt = in_code;
            w.oc = OC_IDENTIFIED;
            w    = go_idle(w, msg_limit, msg_retry_delay, idle_poll_delay);
            fwd  = 1'b1;
          end else begin
            w.oc = OC_UNKNOWN_TYPE;
          end
        end else if (w.np) begin
          fwd = 1'b1;
        end else begin
          w.oc = OC_UNKNOWN_DROP;
        end
      end
      K_ACK: begin
        if (w.np) begin
          w.dl = '0;
          w    = go_idle(w, msg_limit, msg_retry_delay, idle_poll_delay);
        end
      end
      K_NAK: begin
        if (w.np) begin
          w.dl = '0;
          w    = try_send(w, msg_limit, msg_retry_delay, idle_poll_delay);
        end
      end
      K_ERROR: begin
        w.oc = OC_ERROR_RESET;
        w    = link_reset(w, reset_delay);
      end
      default: begin
        w.oc = OC_HANGUP;
        w    = link_reset(w, reset_delay);
      end
    endcase
  end

  // Phase to result code
  always_comb begin
    case (w.phase)
      PH_OPEN:   state_code = LS_OPEN;
      PH_IDENT:  state_code = LS_IDENT;
      PH_IDLE:   state_code = LS_IDLE;
      PH_AWAIT:  state_code = LS_AWAIT;
      PH_STATUS: state_code = LS_STATUS;
      default:   state_code = LS_OPEN;
    endcase
  end

  // Result word packing
  always_comb begin
    res_word = '0;
    res_word[OUT_STATE_LSB +: 3]   = state_code;
    res_word[OUT_SEND_LSB +: 2]    = send;
    res_word[OUT_TX]               = w.tx;
    res_word[OUT_FWD]              = fwd;
    res_word[OUT_PORT_RESET]       = w.pr;
    res_word[OUT_ATTACHED]         = w.np;
    res_word[OUT_TYPE_LSB +: 5]    = w.np ? w.nt : 5'd0;
    res_word[OUT_OUTCOME_LSB +: 4] = w.oc;
  end

  // Link state update
  always_ff @(posedge clk) begin
    if (rst) begin
      link_phase     <= PH_OPEN;
      delay_left     <= sat_delay(RST_RESET_DELAY);
      retries_left   <= '0;
      update_pending <= 1'b0;
      node_present   <= 1'b0;
      node_type      <= '0;
      tx_requested   <= 1'b0;
    end else if (advance) begin
      link_phase     <= w.phase;
      delay_left     <= w.dl;
      retries_left   <= w.rl;
      update_pending <= w.up;
      node_present   <= w.np;
      node_type      <= w.nt;
      tx_requested   <= w.tx;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= res_word;
    end
  end

endmodule

`default_nettype wire

@@ rtl/snlc_checker.sv @@
// ----------------------------------------------------------------------------
// snlc_checker
// Port-level checks on the result stream of the serial node link controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "serial_node_link_controller_top_assert.svh"

module snlc_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [snlc_pkg::OUT_W-1:0] m_tdata
);

  import snlc_pkg::*;

  // A stalled result word stays put
  `SNLC_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // A link reset leaves the port closed in open delay with no node
  `SNLC_ASSERT_NOW(a_reset_closed, m_tvalid && m_tdata[OUT_PORT_RESET], (m_tdata[OUT_STATE_LSB +: 3] == LS_OPEN) && !m_tdata[OUT_ATTACHED] && !m_tdata[OUT_TX], "link reset left port active")

  // No node means no node type
  `SNLC_ASSERT_NOW(a_type_detached, m_tvalid && !m_tdata[OUT_ATTACHED], m_tdata[OUT_TYPE_LSB +: 5] == 5'd0, "node type shown without node")

  // Sending a message consumes the transmit request
  `SNLC_ASSERT_NOW(a_send_clears_tx, m_tvalid && (m_tdata[OUT_SEND_LSB +: 2] != SEND_NONE), !m_tdata[OUT_TX], "transmit request kept after send")

endmodule

bind serial_node_link_controller_top snlc_checker u_snlc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/sv/serial_node_link_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial node link checker
// Watches the event, result and register channels of the link controller.
// Keeps its own copy of the link state and registers, works out the result
// word for every accepted event word, and compares each accepted result word
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module serial_node_link_checker #(
  parameter int unsigned DELAY_WIDTH = snlc_pkg::DELAY_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  input  wire logic                        s_tready,
  input  wire logic [snlc_pkg::IN_W-1:0]   s_tdata,
  input  wire logic [snlc_pkg::USER_W-1:0] s_tuser,
  input  wire logic                        m_tvalid,
  input  wire logic                        m_tready,
  input  wire logic [snlc_pkg::OUT_W-1:0]  m_tdata,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_ready,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [15:0]                 cfg_data,
  output int                               pending,
  output int                               results_checked,
  output int                               mismatches
);

  import snlc_pkg::*;

  // One predicted result word
  typedef struct packed {
    logic [2:0] state;
    send_t      send;
    logic       tx;
    logic       fwd;
    logic       port_reset;
    logic       attached;
    logic [4:0] node;
    outcome_t   outcome;
  } link_result_t;

  link_result_t awaited_results[$];

  // Register copy
  logic [15:0] cfg_regs [0:7];

  // Link state copy
  logic [2:0]  lk_phase;
  logic [31:0] lk_delay;
  logic [4:0]  lk_retries;
  logic        lk_upd;
  logic        lk_node;
  logic [4:0]  lk_type;
  logic        lk_tx;

  // Per-event side results
  outcome_t    last_outcome;
  logic        link_dropped;

  initial begin
    pending         = 0;
    results_checked = 0;
    mismatches      = 0;
  end

  function automatic logic [31:0] clamp_delay(input logic [15:0] v);
    logic [32:0] top_val;
    top_val = (33'd1 << DELAY_WIDTH) - 33'd1;
    if ({17'd0, v} > top_val) return top_val[31:0];
    return {16'd0, v};
  endfunction

  function automatic void init_link();
    cfg_regs[REG_RESET_DELAY]    = RST_RESET_DELAY;
    cfg_regs[REG_OPEN_RETRY]     = RST_OPEN_RETRY;
    cfg_regs[REG_IDENT_TIMEOUT]  = RST_IDENT_TIMEOUT;
    cfg_regs[REG_STATUS_TIMEOUT] = RST_STATUS_TIMEOUT;
    cfg_regs[REG_IDLE_POLL]      = RST_IDLE_POLL;
    cfg_regs[REG_MSG_RETRY]      = RST_MSG_RETRY;
    cfg_regs[REG_IDENT_LIMIT]    = {11'd0, RST_IDENT_LIMIT};
    cfg_regs[REG_MSG_LIMIT]      = {11'd0, RST_MSG_LIMIT};
    lk_phase   = LS_OPEN;
    lk_delay   = clamp_delay(cfg_regs[REG_RESET_DELAY]);
    lk_retries = '0;
    lk_upd     = 1'b0;
    lk_node    = 1'b0;
    lk_type    = '0;
    lk_tx      = 1'b0;
  endfunction

  // Drop the node and go back to the open delay; retries and update flag stay
  function automatic void drop_link();
    lk_node      = 1'b0;
    lk_type      = '0;
    lk_tx        = 1'b0;
    lk_phase     = LS_OPEN;
    lk_delay     = clamp_delay(cfg_regs[REG_RESET_DELAY]);
    link_dropped = 1'b1;
  endfunction

  // One node message attempt; an empty retry budget falls back to idle,
  // which may start the next pending send straight away
  function automatic void send_attempt();
    while (lk_retries == 0) begin
      last_outcome = OC_SEND_DROPPED;
      lk_phase     = LS_IDLE;
      if (!lk_upd) begin
        lk_delay = clamp_delay(cfg_regs[REG_IDLE_POLL]);
        return;
      end
      lk_upd     = 1'b0;
      lk_phase   = LS_AWAIT;
      lk_retries = cfg_regs[REG_MSG_LIMIT][4:0];
    end
    lk_retries = lk_retries - 5'd1;
    lk_delay   = clamp_delay(cfg_regs[REG_MSG_RETRY]);
    lk_tx      = 1'b1;
  endfunction

  function automatic void start_send();
    lk_phase   = LS_AWAIT;
    lk_retries = cfg_regs[REG_MSG_LIMIT][4:0];
    send_attempt();
  endfunction

  function automatic void enter_idle();
    lk_phase = LS_IDLE;
    if (lk_upd) begin
      lk_upd = 1'b0;
      start_send();
    end else begin
      lk_delay = clamp_delay(cfg_regs[REG_IDLE_POLL]);
    end
  endfunction

  function automatic void request_again();
    if (lk_retries != 0) begin
      lk_retries = lk_retries - 5'd1;
      lk_tx      = 1'b1;
    end else begin
      last_outcome = OC_EXHAUSTED;
      drop_link();
    end
  endfunction

  // Countdown ran out: action depends on the phase
  function automatic void delay_expired(input logic port_ok);
    case (lk_phase)
      LS_OPEN: begin
        if (port_ok) begin
          lk_retries   = cfg_regs[REG_IDENT_LIMIT][4:0];
          lk_phase     = LS_IDENT;
          lk_tx        = 1'b1;
          last_outcome = OC_OPENED;
        end else begin
          lk_delay     = clamp_delay(cfg_regs[REG_OPEN_RETRY]);
          last_outcome = OC_OPEN_FAILED;
        end
      end
      LS_IDENT, LS_STATUS: request_again();
      LS_IDLE: begin
        lk_retries = STATUS_RETRIES;
        lk_phase   = LS_STATUS;
        lk_tx      = 1'b1;
      end
      default: send_attempt();
    endcase
  endfunction

  // Advance the link copy by one event word and queue the predicted result
  function automatic void step_link(input logic [USER_W-1:0] user, input logic [IN_W-1:0] w);
    kind_t        kind;
    logic [15:0]  elapsed;
    logic [4:0]   code;
    send_t        msg_sent;
    logic         fwd;
    link_result_t exp;
    kind         = kind_t'(user[2:0]);
    elapsed      = w[IN_ELAPSED_LSB +: 16];
    code         = w[IN_CODE_LSB +: 5];
    msg_sent     = SEND_NONE;
    fwd          = 1'b0;
    last_outcome = OC_NONE;
    link_dropped = 1'b0;
    case (kind)
      K_TICK: begin
        // a zero countdown ignores ticks
        if (lk_delay != 0) begin
          if ({16'd0, elapsed} < lk_delay) begin
            lk_delay = lk_delay - {16'd0, elapsed};
          end else begin
            lk_delay = '0;
            delay_expired(w[IN_PORT_OK]);
          end
        end
      end
      K_UPDATED: begin
        if (lk_phase == LS_IDLE) start_send();
        else lk_upd = 1'b1;
      end
      K_WRITE: begin
        if (lk_phase == LS_AWAIT) begin
          msg_sent = SEND_NODE;
        end else if (lk_phase == LS_STATUS) begin
          msg_sent = SEND_STATUS;
          lk_delay = clamp_delay(cfg_regs[REG_STATUS_TIMEOUT]);
        end else if (lk_phase == LS_IDENT) begin
          msg_sent = SEND_IDENT;
          lk_delay = clamp_delay(cfg_regs[REG_IDENT_TIMEOUT]);
        end
        lk_tx = 1'b0;
      end
      K_MESSAGE: begin
        if (lk_phase == LS_OPEN) begin
          last_outcome = OC_CLOSED;
        end else if (w[IN_INFO]) begin
          last_outcome = OC_INFO;
        end else if (!w[IN_CHECK_OK]) begin
          last_outcome = OC_INVALID;
        end else if (lk_phase == LS_IDENT) begin
          if (!w[IN_IDENTIFY]) begin
            last_outcome = OC_NOT_IDENTIFY;
          end else if (code <= MAX_NODE_TYPE) begin
            lk_node      = 1'b1;
            lk_type      = code;
            last_outcome = OC_IDENTIFIED;
            enter_idle();
            fwd = 1'b1;
          end else begin
            last_outcome = OC_UNKNOWN_TYPE;
          end
        end else if (lk_node) begin
          fwd = 1'b1;
        end else begin
          last_outcome = OC_UNKNOWN_DROP;
        end
      end
      K_ACK: begin
        if (lk_node) begin
          lk_delay = '0;
          enter_idle();
        end
      end
      K_NAK: begin
        if (lk_node) begin
          lk_delay = '0;
          send_attempt();
        end
      end
      K_ERROR: begin
        last_outcome = OC_ERROR_RESET;
        drop_link();
      end
      default: begin
        last_outcome = OC_HANGUP;
        drop_link();
      end
    endcase
    exp.state      = lk_phase;
    exp.send       = msg_sent;
    exp.tx         = lk_tx;
    exp.fwd        = fwd;
    exp.port_reset = link_dropped;
    exp.attached   = lk_node;
    exp.node       = lk_node ? lk_type : 5'd0;
    exp.outcome    = last_outcome;
    awaited_results.push_back(exp);
  endfunction

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at result %0d, %s: expected %0h, got %0h",
               results_checked, field, want, got);
    else if (mismatches == 41)
      $display("further mismatches are counted but not printed");
  endtask

  task automatic check_result(input logic [OUT_W-1:0] w);
    link_result_t exp;
    if (awaited_results.size() == 0) begin
      report("result word with nothing outstanding", '0, 32'(w));
      return;
    end
    exp = awaited_results.pop_front();
    results_checked++;
    if (w[OUT_STATE_LSB +: 3] !== exp.state)
      report("link_state", 32'(exp.state), 32'(w[OUT_STATE_LSB +: 3]));
    if (w[OUT_SEND_LSB +: 2] !== exp.send)
      report("send_kind", 32'(exp.send), 32'(w[OUT_SEND_LSB +: 2]));
    if (w[OUT_TX] !== exp.tx)
      report("transmit_wanted", 32'(exp.tx), 32'(w[OUT_TX]));
    if (w[OUT_FWD] !== exp.fwd)
      report("forward_to_node", 32'(exp.fwd), 32'(w[OUT_FWD]));
    if (w[OUT_PORT_RESET] !== exp.port_reset)
      report("port_reset", 32'(exp.port_reset), 32'(w[OUT_PORT_RESET]));
    if (w[OUT_ATTACHED] !== exp.attached)
      report("node_attached", 32'(exp.attached), 32'(w[OUT_ATTACHED]));
    if (w[OUT_TYPE_LSB +: 5] !== exp.node)
      report("attached_type", 32'(exp.node), 32'(w[OUT_TYPE_LSB +: 5]));
    if (w[OUT_OUTCOME_LSB +: 4] !== exp.outcome)
      report("outcome", 32'(exp.outcome), 32'(w[OUT_OUTCOME_LSB +: 4]));
    if (w[OUT_W-1:OUT_OUTCOME_LSB+4] !== '0)
      report("zero fill", '0, 32'(w[OUT_W-1:OUT_OUTCOME_LSB+4]));
  endtask

  // Channel monitor: results first, then register writes, then new events
  always @(posedge clk) begin
    if (rst) begin
      init_link();
      awaited_results.delete();
      pending = 0;
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_IDENT_LIMIT || cfg_index == REG_MSG_LIMIT)
          cfg_regs[cfg_index] = {11'd0, cfg_data[4:0]};
        else
          cfg_regs[cfg_index] = cfg_data;
      end
      if (s_tvalid && s_tready) step_link(s_tuser, s_tdata);
      pending = awaited_results.size();
    end
  end

endmodule

@@ tb/sv/serial_node_link_controller_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial node link controller testbench
// Drives link events into the controller: a short directed walk through every
// phase and special case, then random link sessions (open, identify, node
// traffic, polls, failures) mixed with noise, under several register
// settings including all-zero and full-scale. Both stream sides idle at
// random. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module serial_node_link_controller_top_tb;
  import snlc_pkg::*;

  // Message flag bits for make_event
  localparam logic [3:0] F_PORT  = 4'b0001;
  localparam logic [3:0] F_INFO  = 4'b0010;
  localparam logic [3:0] F_CHECK = 4'b0100;
  localparam logic [3:0] F_IDENT = 4'b1000;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] elapsed;
    logic        port_ok;
    logic        info;
    logic        check_ok;
    logic        ident;
    logic [4:0]  code;
  } link_event_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  wire logic         s_tready;
  logic [IN_W-1:0]   s_tdata;
  logic [USER_W-1:0] s_tuser;
  wire logic         m_tvalid;
  logic              m_tready;
  wire [OUT_W-1:0]   m_tdata;
  logic              cfg_valid;
  wire logic         cfg_ready;
  logic [2:0]        cfg_index;
  logic [15:0]       cfg_data;

  int pending;
  int results_checked;
  int mismatches;

  int          events_sent;
  int          settings_used;
  bit          idle_off;
  logic [15:0] next_regs [0:7];

  serial_node_link_controller_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  serial_node_link_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pending        (pending),
    .results_checked(results_checked),
    .mismatches     (mismatches)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_wait();
    return idle_off ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic link_event_t make_event(input kind_t k, input logic [15:0] el,
                                             input logic [3:0] fl, input logic [4:0] cd);
    link_event_t e;
    e.kind     = k;
    e.elapsed  = el;
    e.port_ok  = fl[0];
    e.info     = fl[1];
    e.check_ok = fl[2];
    e.ident    = fl[3];
    e.code     = cd;
    return e;
  endfunction

  // Fully random event word
  function automatic link_event_t any_event();
    logic [15:0] el;
    case ($urandom_range(0, 3))
      0:       el = 16'hFFFF;
      1:       el = 16'($urandom);
      default: el = 16'($urandom_range(0, 400));
    endcase
    return make_event(kind_t'($urandom_range(0, 7)), el, 4'($urandom),
                      5'($urandom_range(0, 31)));
  endfunction

  // Random event of a given kind
  function automatic link_event_t event_of(input kind_t k);
    link_event_t e;
    e      = any_event();
    e.kind = k;
    return e;
  endfunction

  // Tick long enough to expire any countdown
  function automatic link_event_t expiry(input logic port_ok);
    link_event_t e;
    e         = event_of(K_TICK);
    e.elapsed = 16'hFFFF;
    e.port_ok = port_ok;
    return e;
  endfunction

  // Well-formed message; identify responses carry a known node type
  function automatic link_event_t good_message(input logic ident);
    link_event_t e;
    e          = event_of(K_MESSAGE);
    e.info     = 1'b0;
    e.check_ok = 1'b1;
    e.ident    = ident;
    if (ident) e.code = 5'($urandom_range(0, MAX_NODE_TYPE));
    return e;
  endfunction

  // Present one event word after a random gap and wait for its acceptance
  task automatic offer(input link_event_t e);
    int              gap;
    logic [IN_W-1:0] w;
    gap = pick_wait();
    w   = '0;
    w[IN_ELAPSED_LSB +: 16] = e.elapsed;
    w[IN_PORT_OK]           = e.port_ok;
    w[IN_INFO]              = e.info;
    w[IN_CHECK_OK]          = e.check_ok;
    w[IN_IDENTIFY]          = e.ident;
    w[IN_CODE_LSB +: 5]     = e.code;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = w;
    s_tuser  = e.kind;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    events_sent++;
  endtask

  // Stop sending and wait until every outstanding result word is back
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all eight registers from next_regs while the link is quiet
  task automatic program_regs();
    wait_drained();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_index = reg_index_t'(i);
      cfg_data  = next_regs[i];
      cfg_valid = 1'b1;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
      cfg_valid = 1'b0;
    end
    settings_used++;
  endtask

  // One link session: reset, open, identify, then node traffic
  task automatic run_session();
    logic ok;
    int   steps;
    idle_off = ($urandom_range(0, 3) == 0);
    offer(event_of($urandom_range(0, 3) == 0 ? K_ERROR : K_HANGUP));
    ok = ($urandom_range(0, 3) != 0);
    offer(expiry(ok));
    if (!ok) offer(expiry(1'b1));
    offer(event_of(K_WRITE));
    repeat ($urandom_range(0, 2)) offer(event_of(K_MESSAGE));
    if ($urandom_range(0, 5) == 0) offer(expiry(1'($urandom)));
    offer(good_message(1'b1));
    steps = $urandom_range(3, 14);
    repeat (steps) begin
      case ($urandom_range(0, 7))
        0: begin
          offer(event_of(K_UPDATED));
          offer(event_of(K_WRITE));
          offer(event_of(K_ACK));
        end
        1: begin
          offer(event_of(K_UPDATED));
          offer(event_of(K_WRITE));
          offer(event_of(K_NAK));
          offer(event_of(K_WRITE));
          offer(event_of(K_ACK));
        end
        2: begin
          // node message times out and is sent again
          offer(event_of(K_UPDATED));
          offer(event_of(K_WRITE));
          offer(expiry(1'($urandom)));
          offer(event_of(K_WRITE));
          offer(event_of(K_ACK));
        end
        3: begin
          // status poll answered
          offer(expiry(1'($urandom)));
          offer(event_of(K_WRITE));
          offer(good_message(1'($urandom)));
          offer(event_of(K_ACK));
        end
        4: begin
          // status poll with a retry
          offer(expiry(1'($urandom)));
          offer(event_of(K_WRITE));
          offer(expiry(1'($urandom)));
          offer(event_of(K_WRITE));
          offer(event_of($urandom_range(0, 1) ? K_ACK : K_NAK));
        end
        5: offer(event_of(K_TICK));
        6: offer(any_event());
        default: begin
          // second update arrives while the first is in flight
          offer(event_of(K_UPDATED));
          offer(event_of(K_UPDATED));
          offer(event_of(K_WRITE));
          offer(event_of(K_ACK));
          offer(event_of(K_WRITE));
          offer(event_of(K_ACK));
        end
      endcase
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
  endtask

  task automatic run_segment(input int n);
    int stop;
    stop = events_sent + n;
    while (events_sent < stop) begin
      if ($urandom_range(0, 4) == 0) offer(any_event());
      else run_session();
    end
  endtask

  // Result side: random stall before each word
  initial begin
    int stall;
    m_tready = 1'b0;
    forever begin
      stall = pick_wait();
      @(negedge clk);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Stimulus
  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    events_sent   = 0;
    settings_used = 1;
    idle_off      = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed walk under reset register values
    offer(make_event(K_MESSAGE, 16'd0, F_CHECK | F_IDENT, 5'd0));    // closed port
    offer(make_event(K_ACK, 16'd0, 4'b0000, 5'd0));                  // no node
    offer(make_event(K_WRITE, 16'hFFFF, 4'b1111, 5'd31));            // nothing to send
    offer(make_event(K_UPDATED, 16'd0, 4'b0000, 5'd0));              // update held
    offer(make_event(K_TICK, 16'd0, F_PORT, 5'd0));
    offer(make_event(K_TICK, 16'd999, F_PORT, 5'd0));
    offer(make_event(K_TICK, 16'hFFFF, 4'b0000, 5'd0));              // open fails
    offer(make_event(K_TICK, 16'hFFFF, F_PORT, 5'd0));               // opens
    offer(make_event(K_WRITE, 16'd0, 4'b0000, 5'd0));                // identify request
    offer(make_event(K_MESSAGE, 16'd0, F_INFO | F_CHECK | F_IDENT, 5'd3));
    offer(make_event(K_MESSAGE, 16'd0, F_IDENT, 5'd3));              // bad check count
    offer(make_event(K_MESSAGE, 16'd0, F_CHECK, 5'd3));              // not identify
    offer(make_event(K_MESSAGE, 16'd0, F_CHECK | F_IDENT, 5'd19));   // unknown type
    offer(make_event(K_MESSAGE, 16'd0, F_CHECK | F_IDENT, 5'd18));   // identified
    offer(make_event(K_WRITE, 16'd0, 4'b0000, 5'd0));                // node message
    offer(make_event(K_NAK, 16'd0, 4'b0000, 5'd0));
    offer(make_event(K_WRITE, 16'd0, 4'b0000, 5'd0));
    offer(make_event(K_ACK, 16'd0, 4'b0000, 5'd0));
    offer(make_event(K_WRITE, 16'd0, 4'b0000, 5'd0));                // idle: nothing
    offer(make_event(K_MESSAGE, 16'd0, F_CHECK, 5'd0));              // forwarded
    offer(make_event(K_TICK, 16'hFFFF, 4'b0000, 5'd0));              // status poll
    offer(make_event(K_WRITE, 16'd0, 4'b0000, 5'd0));
    offer(make_event(K_UPDATED, 16'd0, 4'b0000, 5'd0));
    offer(make_event(K_ACK, 16'd0, 4'b0000, 5'd0));                  // pending send starts
    offer(make_event(K_ERROR, 16'd0, 4'b0000, 5'd0));
    offer(make_event(K_HANGUP, 16'd0, 4'b0000, 5'd0));

    // Random sessions under a range of register settings
    for (int s = 0; s < 6; s++) begin
      for (int i = 0; i < 8; i++) begin
        case (s)
          0: next_regs[i] = (i < 6) ? 16'($urandom_range(1, 3000)) : 16'($urandom_range(1, 6));
          1: next_regs[i] = (i < 6) ? 16'hFFFF : 16'd31;
          2: next_regs[i] = 16'd0;
          3: next_regs[i] = (i < 6) ? 16'($urandom_range(1, 50)) : 16'd0;
          4: next_regs[i] = 16'($urandom);
          default: next_regs[i] = (i < 6) ? 16'($urandom_range(1, 300))
                                          : 16'($urandom_range(1, 4));
        endcase
      end
      // upper bits of the limit registers are don't-care on the bus
      if (s == 4) begin
        next_regs[REG_IDENT_LIMIT][4:0] = 5'($urandom_range(0, 5));
        next_regs[REG_MSG_LIMIT][4:0]   = 5'($urandom_range(0, 5));
      end
      program_regs();
      case (s)
        2:       run_segment(60);
        5:       run_segment(400);
        1:       run_segment(300);
        default: run_segment(350);
      endcase
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d link events under %0d register settings; %0d result words compared.",
             events_sent, settings_used, results_checked);
    $display("Settings ranged from all-zero to full-scale delays and retry limits.");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/snlc_pkg.sv
rtl/serial_node_link_controller_top.sv
rtl/snlc_checker.sv
tb/sv/serial_node_link_checker.sv
tb/sv/serial_node_link_controller_top_tb.sv
